[rtl/core/vfr_pkg.sv]
// Shared types and constants for the video frame reassembler.
// Used by video_frame_reassembler; no dependencies.
package vfr_pkg;

  localparam int unsigned HeaderLen   = 88;
  localparam int unsigned FifoDepth   = 4;
  localparam int unsigned FifoAw      = $clog2(FifoDepth);
  localparam int unsigned OutDataW    = 120;

  localparam logic [6:0]  PosMax      = 7'd127;
  localparam logic [27:0] CollectMax  = 28'h0FFF_FFFF;

  localparam logic [15:0] MaxDimRst   = 16'd8192;
  localparam logic [27:0] MaxSizeRst  = 28'h800_0000;

  // header byte positions in a frame's first packet, data start in later packets
  localparam logic [6:0] PosWidthLo   = 7'd15;
  localparam logic [6:0] PosWidthHi   = 7'd16;
  localparam logic [6:0] PosHeightLo  = 7'd17;
  localparam logic [6:0] PosHeightHi  = 7'd18;
  localparam logic [6:0] PosMode      = 7'd44;
  localparam logic [6:0] PosJpeg      = 7'd46;
  localparam logic [6:0] PosAdvance   = 7'd49;
  localparam logic [6:0] PosCipher    = 7'd55;
  localparam logic [6:0] PosChroma    = 7'd57;
  localparam logic [6:0] PosSize0     = 7'd71;
  localparam logic [6:0] PosSize1     = 7'd72;
  localparam logic [6:0] PosSize2     = 7'd73;
  localparam logic [6:0] PosSize3     = 7'd74;
  localparam logic [6:0] PosContData  = 7'd2;

  // configuration register indexes
  localparam logic CfgMaxDim  = 1'b0;
  localparam logic CfgMaxSize = 1'b1;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_FRAME = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_SHORT_PKT   = 3'd0,
    ERR_SHORT_FIRST = 3'd1,
    ERR_BAD_DIMS    = 3'd2,
    ERR_BAD_SIZE    = 3'd3,
    ERR_OVERFLOW    = 3'd4
  } err_code_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic [15:0] width;
    logic [15:0] height;
    logic [7:0]  mode;
    logic [7:0]  jpeg;
    logic [7:0]  advance;
    logic [7:0]  cipher;
    logic [7:0]  chroma;
    logic [31:0] size;
    err_code_t   err;
  } result_t;

endpackage

[rtl/core/video_frame_reassembler.sv]
// Video frame reassembler top level: header capture, checks and result queue.
// Depends on vfr_pkg.
//
// One payload byte is taken per transaction, and a new byte can be accepted in
// every cycle while in_tready is high. Each byte produces at most two results:
// a compressed data byte and, on the tlast byte, a frame-complete or error
// report. Results go into a four-entry queue drained one per cycle on the out_
// side while out_tready is high; in_tready drops while fewer than two slots
// are free, so one-result bytes sustain one byte per cycle while the output
// drains. Header fields of the current frame travel with every result.
// Configuration writes are always accepted and are meant to land while idle.
module video_frame_reassembler
  import vfr_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,   // [7:0] data_byte
  input  logic                in_tlast,   // packet_end
  output logic                out_tvalid,
  input  logic                out_tready,
  // [7:0] out_byte, [23:8] frame_width, [39:24] frame_height,
  // [47:40] compress_mode, [55:48] jpeg_table, [63:56] advance_table,
  // [71:64] cipher_enable, [79:72] chroma_420, [111:80] declared_size,
  // [114:112] error_code, [119:115] zero
  output logic [OutDataW-1:0] out_tdata,
  output logic [1:0]          out_tuser,  // [1:0] kind
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [27:0]         cfg_data
);

  logic [15:0] max_dim_r;
  logic [27:0] max_size_r;

  logic        await_r, await_nxt;
  logic [6:0]  pos_r, pos_nxt;
  logic [15:0] width_r, width_nxt;
  logic [15:0] height_r, height_nxt;
  logic [7:0]  mode_r, mode_nxt;
  logic [7:0]  jpeg_r, jpeg_nxt;
  logic [7:0]  adv_r, adv_nxt;
  logic [7:0]  cipher_r, cipher_nxt;
  logic [7:0]  chroma_r, chroma_nxt;
  logic [31:0] size_r, size_nxt;
  logic [27:0] coll_r, coll_nxt;
  logic        ovf_r, ovf_nxt;

  result_t            fifo_r [FifoDepth];
  logic [FifoAw-1:0]  wr_ptr_r, rd_ptr_r;
  logic [FifoAw:0]    count_r;

  logic        in_acc, out_acc;
  logic        clr, dims_bad, size_bad, want_data, can_take, emit_data;
  logic        err_hit, complete, emit_end;
  err_code_t   err_code;
  logic [27:0] coll_base;
  logic        ovf_base;
  result_t     res_data, res_end;

  assign cfg_ready  = 1'b1;
  assign in_acc     = in_tvalid && in_tready;
  assign out_acc    = out_tvalid && out_tready;
  assign in_tready  = count_r <= (FifoAw+1)'(FifoDepth - 2);
  assign out_tvalid = count_r != '0;

  always_comb begin
    clr        = await_r && (pos_r == '0);
    width_nxt  = clr ? '0 : width_r;
    height_nxt = clr ? '0 : height_r;
    mode_nxt   = clr ? '0 : mode_r;
    jpeg_nxt   = clr ? '0 : jpeg_r;
    adv_nxt    = clr ? '0 : adv_r;
    cipher_nxt = clr ? '0 : cipher_r;
    chroma_nxt = clr ? '0 : chroma_r;
    size_nxt   = clr ? '0 : size_r;
    coll_base  = clr ? '0 : coll_r;
    ovf_base   = clr ? 1'b0 : ovf_r;

    if (await_r) begin
      case (pos_r)
        PosWidthLo:  width_nxt[7:0]   = in_tdata;
        PosWidthHi:  width_nxt[15:8]  = in_tdata;
        PosHeightLo: height_nxt[7:0]  = in_tdata;
        PosHeightHi: height_nxt[15:8] = in_tdata;
        PosMode:     mode_nxt         = in_tdata;
        PosJpeg:     jpeg_nxt         = in_tdata;
        PosAdvance:  adv_nxt          = in_tdata;
        PosCipher:   cipher_nxt       = in_tdata;
        PosChroma:   chroma_nxt       = in_tdata;
        PosSize0:    size_nxt[7:0]    = in_tdata;
        PosSize1:    size_nxt[15:8]   = in_tdata;
        PosSize2:    size_nxt[23:16]  = in_tdata;
        PosSize3:    size_nxt[31:24]  = in_tdata;
        default: ;
      endcase
    end

    dims_bad = (width_nxt == '0) || (height_nxt == '0) ||
               (width_nxt > max_dim_r) || (height_nxt > max_dim_r);
    size_bad = (size_nxt == '0) || (size_nxt > {4'b0, max_size_r});

    want_data = await_r ? ((pos_r >= 7'(HeaderLen)) && !dims_bad && !size_bad)
                        : (pos_r >= PosContData);
    can_take  = ({4'b0, coll_base} < size_nxt) && (coll_base != CollectMax);
    emit_data = want_data && can_take;
    coll_nxt  = emit_data ? coll_base + 28'd1 : coll_base;
    ovf_nxt   = ovf_base || (want_data && !can_take);

    err_hit  = 1'b1;
    err_code = ERR_SHORT_PKT;
    priority if (pos_r == '0) begin
      err_code = ERR_SHORT_PKT;
    end else if (await_r && (pos_r < 7'(HeaderLen - 1))) begin
      err_code = ERR_SHORT_FIRST;
    end else if (await_r && dims_bad) begin
      err_code = ERR_BAD_DIMS;
    end else if (await_r && size_bad) begin
      err_code = ERR_BAD_SIZE;
    end else if (ovf_nxt) begin
      err_code = ERR_OVERFLOW;
    end else begin
      err_hit = 1'b0;
    end
    complete = !err_hit && ({4'b0, coll_nxt} == size_nxt);
    emit_end = in_tlast && (err_hit || complete);

    if (in_tlast) begin
      await_nxt = err_hit || complete;
      pos_nxt   = '0;
    end else begin
      await_nxt = await_r;
      pos_nxt   = (pos_r == PosMax) ? pos_r : pos_r + 7'd1;
    end

    res_data.kind    = KIND_DATA;
    res_data.data    = in_tdata;
    res_data.width   = width_nxt;
    res_data.height  = height_nxt;
    res_data.mode    = mode_nxt;
    res_data.jpeg    = jpeg_nxt;
    res_data.advance = adv_nxt;
    res_data.cipher  = cipher_nxt;
    res_data.chroma  = chroma_nxt;
    res_data.size    = size_nxt;
    res_data.err     = ERR_SHORT_PKT;

    res_end      = res_data;
    res_end.kind = err_hit ? KIND_ERROR : KIND_FRAME;
    res_end.data = '0;
    res_end.err  = err_hit ? err_code : ERR_SHORT_PKT;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_dim_r  <= MaxDimRst;
      max_size_r <= MaxSizeRst;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CfgMaxDim:  max_dim_r  <= cfg_data[15:0];
        CfgMaxSize: max_size_r <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      await_r  <= 1'b1;
      pos_r    <= '0;
      width_r  <= '0;
      height_r <= '0;
      mode_r   <= '0;
      jpeg_r   <= '0;
      adv_r    <= '0;
      cipher_r <= '0;
      chroma_r <= '0;
      size_r   <= '0;
      coll_r   <= '0;
      ovf_r    <= 1'b0;
    end else if (in_acc) begin
      await_r  <= await_nxt;
      pos_r    <= pos_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      mode_r   <= mode_nxt;
      jpeg_r   <= jpeg_nxt;
      adv_r    <= adv_nxt;
      cipher_r <= cipher_nxt;
      chroma_r <= chroma_nxt;
      size_r   <= size_nxt;
      coll_r   <= coll_nxt;
      ovf_r    <= in_tlast ? 1'b0 : ovf_nxt;
    end
  end

  // result queue: data result first, packet-end result behind it
  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (emit_data) begin
        fifo_r[wr_ptr_r] <= res_data;
      end
      if (emit_end) begin
        fifo_r[emit_data ? wr_ptr_r + FifoAw'(1) : wr_ptr_r] <= res_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (in_acc) begin
        wr_ptr_r <= wr_ptr_r + FifoAw'(emit_data) + FifoAw'(emit_end);
      end
      if (out_acc) begin
        rd_ptr_r <= rd_ptr_r + FifoAw'(1);
      end
      count_r <= count_r
               + ((in_acc && emit_data) ? (FifoAw+1)'(1) : '0)
               + ((in_acc && emit_end) ? (FifoAw+1)'(1) : '0)
               - (out_acc ? (FifoAw+1)'(1) : '0);
    end
  end

  result_t head;
  assign head      = fifo_r[rd_ptr_r];
  assign out_tuser = head.kind;
  assign out_tdata = {5'b0, head.err, head.size, head.chroma, head.cipher,
                      head.advance, head.jpeg, head.mode, head.height,
                      head.width, head.data};

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (FifoAw+1)'(FifoDepth))
    else $error("result queue count beyond depth");

  a_collect_le_size: assert property (@(posedge clk) disable iff (!rst_n)
    {4'b0, coll_r} <= size_r)
    else $error("collected bytes exceed declared size");

  a_data_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (head.kind == KIND_DATA) |-> head.err == ERR_SHORT_PKT)
    else $error("data result carries an error code");

  a_report_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (head.kind != KIND_DATA) |-> head.data == '0)
    else $error("report result carries a data byte");

  a_end_resets_pos: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tlast |=> pos_r == '0 && !ovf_r)
    else $error("packet end did not restart position tracking");

endmodule
